// ===== hdl/lrws_pkg.sv =====
// Shared types and constants for the label run window splitter.
package lrws_pkg;

    localparam int LABEL_W    = 16;
    localparam int POS_OUT_W  = 12;
    localparam int TOP_W      = 5;
    localparam int BOT_W      = 5;
    localparam int MWL_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [MWL_W-1:0] MWL_RESET = 13'd256;

    localparam logic [CFG_IDX_W-1:0] REG_TOP_MARGIN        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_MARGIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WINDOW_LENGTH = 2'd2;

    typedef struct packed {
        logic [LABEL_W-1:0] frame_label;
        logic               segment_end;
    } in_item_t;

    typedef struct packed {
        logic [LABEL_W-1:0]   window_label;
        logic [POS_OUT_W-1:0] window_start;
        logic [POS_OUT_W-1:0] window_end;
        logic                 broken;
        logic                 last_of_run;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic load_b;
        logic set_single;
        logic div_start;
        logic div_sel;
        logic set_pieces;
        logic set_split;
        logic emit;
        logic last_of_run;
    } dp_cmd_t;

    typedef struct packed {
        logic cur_valid;
        logic pend_b;
        logic fits;
        logic div_busy;
        logic last_piece;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/label_run_window_splitter.sv =====
// Top level: frame label run segmentation into bounded windows.
// Sequence: an item that closes no run is accepted in IDLE and dropped in PICK; a run that
// fits in one window passes PICK and CHECK before EMIT loads it into the output register.
// A split run first takes two divisions on the shared serial divider (piece count, then
// piece length), then emits one piece per cycle while the output register is free.
// Reset (rst_n, async, active low) clears control, segment state and configuration;
// the delay line contents are not reset.
module label_run_window_splitter import lrws_pkg::*; #(
    parameter int MAX_FRAMES = 4096,
    parameter int MAX_MARGIN = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    lrws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lrws_dp #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_MARGIN (MAX_MARGIN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== hdl/lrws_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module lrws_div #(
    parameter int W = 13
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[W-1]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = CNT_W'(W);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[W-2:0], ge};
            rem_next = ge ? diff[W-1:0] : trial[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/lrws_dp.sv =====
// Datapath: configuration, frame bookkeeping, delay line, run splitter and output register.
module lrws_dp import lrws_pkg::*; #(
    parameter int MAX_FRAMES = 4096,
    parameter int MAX_MARGIN = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  in_item_t              in_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    localparam int FIDX_W     = $clog2(MAX_FRAMES + 1);
    localparam int FILL_W     = $clog2(MAX_MARGIN + 1);
    localparam int MIN_WINDOW = (MAX_FRAMES / 32 > 128) ? MAX_FRAMES / 32 : 128;

    // configuration
    logic [TOP_W-1:0] top_reg;
    logic [BOT_W-1:0] bot_reg;
    logic [MWL_W-1:0] mwl_reg;

    // segment state
    logic [FIDX_W-1:0]  fidx_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               run_open_reg;
    logic [LABEL_W-1:0] run_lbl_reg;
    logic [FIDX_W-1:0]  run_start_reg;
    logic [LABEL_W-1:0] dl_reg  [MAX_MARGIN];
    logic [LABEL_W-1:0] dl_next [MAX_MARGIN];
    logic [LABEL_W-1:0] dl_up   [MAX_MARGIN];

    // splitter
    logic               cur_valid_reg;
    logic               pend_b_reg;
    logic [LABEL_W-1:0] e_lbl_reg;
    logic [FIDX_W-1:0]  pos_reg;
    logic [FIDX_W-1:0]  dur_reg;
    logic [FIDX_W-1:0]  pieces_reg;
    logic [FIDX_W-1:0]  len_reg;
    logic [FIDX_W-1:0]  extra_reg;
    logic [FIDX_W-1:0]  cnt_reg;
    logic               broken_reg;
    logic [LABEL_W-1:0] pb_lbl_reg;
    logic [FIDX_W-1:0]  pb_start_reg;
    logic [FIDX_W-1:0]  pb_dur_reg;

    // output stage
    logic      out_valid_reg;
    out_item_t out_data_reg;

    // bookkeeping
    logic               in_range, grow, pop, proc, a_fire, open_new, b_fire, restart;
    logic [31:0]        b_sat;
    logic [FIDX_W-1:0]  idx, fidx_inc, end_b, start_new;
    logic [FILL_W-1:0]  fill_inc;
    logic [LABEL_W-1:0] popped, lbl_new;

    logic [MWL_W-1:0]  m_eff;
    logic [31:0]       m32;
    logic [FIDX_W-1:0] div_divisor, div_quo, div_rem;
    logic              div_busy;

    logic [FIDX_W-1:0] plen, wend;
    logic [31:0]       wstart32, wend32;
    out_item_t         win;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
            bot_reg <= '0;
            mwl_reg <= MWL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TOP_MARGIN:        top_reg <= cfg_data[TOP_W-1:0];
                REG_BOTTOM_MARGIN:     bot_reg <= cfg_data[BOT_W-1:0];
                REG_MAX_WINDOW_LENGTH: mwl_reg <= cfg_data[MWL_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        in_range  = (32'(fidx_reg) < MAX_FRAMES);
        b_sat     = (32'(bot_reg) > MAX_MARGIN) ? 32'(MAX_MARGIN) : 32'(bot_reg);
        grow      = in_range && (32'(fill_reg) < b_sat);
        pop       = in_range && !grow;
        idx       = fidx_reg - FIDX_W'(fill_reg);
        popped    = (fill_reg == '0) ? in_data.frame_label : dl_reg[0];
        proc      = pop && (32'(idx) >= 32'(top_reg));
        a_fire    = proc && run_open_reg && (popped != run_lbl_reg);
        restart   = proc && (!run_open_reg || a_fire);
        open_new  = run_open_reg || proc;
        lbl_new   = restart ? popped : run_lbl_reg;
        start_new = restart ? idx : run_start_reg;
        fidx_inc  = fidx_reg + FIDX_W'(in_range);
        fill_inc  = fill_reg + FILL_W'(grow);
        end_b     = fidx_inc - FIDX_W'(fill_inc);
        b_fire    = in_data.segment_end && open_new && (end_b > start_new);
    end

    // shift source for each delay tap
    for (genvar g = 0; g < MAX_MARGIN; g++)
    begin : g_up
        if (g < MAX_MARGIN - 1)
        begin : g_mid
            assign dl_up[g] = dl_reg[g+1];
        end
        else
        begin : g_tail
            assign dl_up[g] = dl_reg[g];
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_MARGIN; i++)
        begin
            dl_next[i] = dl_reg[i];
            if (grow && (fill_reg == FILL_W'(i)))
            begin
                dl_next[i] = in_data.frame_label;
            end
            else if (pop && (fill_reg != '0))
            begin
                if (fill_reg == FILL_W'(i + 1))
                begin
                    dl_next[i] = in_data.frame_label;
                end
                else if (FILL_W'(i + 1) < fill_reg)
                begin
                    dl_next[i] = dl_up[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dl_reg        <= dl_next;
            run_lbl_reg   <= lbl_new;
            run_start_reg <= start_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fidx_reg      <= '0;
            fill_reg      <= '0;
            run_open_reg  <= 1'b0;
            cur_valid_reg <= 1'b0;
            pend_b_reg    <= 1'b0;
        end
        else if (cmd.accept)
        begin
            cur_valid_reg <= a_fire;
            pend_b_reg    <= b_fire;
            if (in_data.segment_end)
            begin
                fidx_reg     <= '0;
                fill_reg     <= '0;
                run_open_reg <= 1'b0;
            end
            else
            begin
                fidx_reg     <= fidx_inc;
                fill_reg     <= fill_inc;
                run_open_reg <= open_new;
            end
        end
        else if (cmd.load_b)
        begin
            pend_b_reg <= 1'b0;
        end
    end

    // clamp the window length and route the shared divider
    always_comb
    begin
        m_eff       = (32'(mwl_reg) < MIN_WINDOW) ? MWL_W'(MIN_WINDOW) : mwl_reg;
        m32         = 32'(m_eff);
        div_divisor = cmd.div_sel ? pieces_reg : m32[FIDX_W-1:0];
    end

    lrws_div #(
        .W (FIDX_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dur_reg),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            e_lbl_reg    <= run_lbl_reg;
            pos_reg      <= run_start_reg;
            dur_reg      <= idx - run_start_reg;
            pb_lbl_reg   <= lbl_new;
            pb_start_reg <= start_new;
            pb_dur_reg   <= end_b - start_new;
        end
        if (cmd.set_single)
        begin
            pieces_reg <= FIDX_W'(1);
            len_reg    <= dur_reg;
            extra_reg  <= '0;
            cnt_reg    <= '0;
            broken_reg <= 1'b0;
        end
        if (cmd.set_pieces)
        begin
            pieces_reg <= div_quo + FIDX_W'(div_rem != '0);
        end
        if (cmd.set_split)
        begin
            len_reg    <= div_quo;
            extra_reg  <= div_rem;
            cnt_reg    <= '0;
            broken_reg <= 1'b1;
        end
        if (cmd.emit)
        begin
            if (!cmd.load_b)
            begin
                pos_reg <= pos_reg + plen;
            end
            cnt_reg      <= cnt_reg + 1'b1;
            out_data_reg <= win;
        end
        // the pending second run takes over once the first one is done, or at once if there is none
        if (cmd.load_b)
        begin
            e_lbl_reg <= pb_lbl_reg;
            pos_reg   <= pb_start_reg;
            dur_reg   <= pb_dur_reg;
        end
    end

    // longer pieces come first
    always_comb
    begin
        plen     = len_reg + FIDX_W'(cnt_reg < extra_reg);
        wend     = pos_reg + plen - FIDX_W'(1);
        wstart32 = 32'(pos_reg);
        wend32   = 32'(wend);
        win.window_label = e_lbl_reg;
        win.window_start = wstart32[POS_OUT_W-1:0];
        win.window_end   = wend32[POS_OUT_W-1:0];
        win.broken       = broken_reg;
        win.last_of_run  = cmd.last_of_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        status.cur_valid  = cur_valid_reg;
        status.pend_b     = pend_b_reg;
        status.fits       = (32'(dur_reg) <= m32);
        status.div_busy   = div_busy;
        status.last_piece = (cnt_reg == pieces_reg - FIDX_W'(1));
        status.out_free   = !out_valid_reg || !out_stall;
    end

`ifndef NO_ASSERTIONS
    a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("window loaded while output register still held");

    a_piece_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (cnt_reg < pieces_reg))
        else $error("piece counter ran past piece count");

    a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_frame_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(fidx_reg) <= MAX_FRAMES) && (32'(fill_reg) <= MAX_MARGIN))
        else $error("frame index or delay fill out of bounds");
`endif

endmodule

// ===== hdl/lrws_ctrl.sv =====
// Controller: sequences frame acceptance, run splitting and window emission.
module lrws_ctrl import lrws_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PICK  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_WAIT1 = 3'd3;
    localparam logic [2:0] S_DIV2  = 3'd4;
    localparam logic [2:0] S_WAIT2 = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (status.cur_valid)
                begin
                    state_next = S_CHECK;
                end
                else if (status.pend_b)
                begin
                    cmd.load_b = 1'b1;
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (status.fits)
                begin
                    cmd.set_single = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_WAIT1;
                end
            end
            S_WAIT1:
            begin
                if (!status.div_busy)
                begin
                    cmd.set_pieces = 1'b1;
                    state_next     = S_DIV2;
                end
            end
            S_DIV2:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = S_WAIT2;
            end
            S_WAIT2:
            begin
                // hold the piece count on the divisor while the divider runs
                cmd.div_sel = 1'b1;
                if (!status.div_busy)
                begin
                    cmd.set_split = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.last_of_run = status.last_piece && !status.pend_b;
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_piece)
                    begin
                        if (status.pend_b)
                        begin
                            cmd.load_b = 1'b1;
                            state_next = S_CHECK;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== dv/label_run_window_splitter_tb.sv =====
// Self-checking testbench for the label run window splitter: random and directed frames.
module label_run_window_splitter_tb;
    import lrws_pkg::*;

    localparam int FRAME_CAP      = 4096;
    localparam int MARGIN_CAP     = 16;
    localparam int RESULT_CAP     = 64;
    localparam int MIN_WIN        = (FRAME_CAP / 32 > 128) ? FRAME_CAP / 32 : 128;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 120;
    localparam int WATCHDOG_LIMIT = 20000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    class window_tracker;
        logic [TOP_W-1:0]   top_m;
        logic [BOT_W-1:0]   bot_m;
        logic [MWL_W-1:0]   max_len;
        logic [LABEL_W-1:0] run_lbl;
        bit                 run_open;
        int unsigned        run_beg;
        int unsigned        frame_cnt;
        logic [LABEL_W-1:0] held[MARGIN_CAP];
        int unsigned        held_n;
        out_item_t          step_out[$];
        out_item_t          windows_due[$];
        int unsigned        mismatches;

        function new();
            top_m      = '0;
            bot_m      = '0;
            max_len    = MWL_RESET;
            mismatches = 0;
            clear_segment();
        endfunction

        function void clear_segment();
            run_lbl   = '0;
            run_open  = 1'b0;
            run_beg   = 0;
            frame_cnt = 0;
            held_n    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TOP_MARGIN:        top_m = val[TOP_W-1:0];
                REG_BOTTOM_MARGIN:     bot_m = val[BOT_W-1:0];
                REG_MAX_WINDOW_LENGTH: max_len = val[MWL_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_window(logic [LABEL_W-1:0] lbl, int unsigned s, int unsigned e,
                                 bit brk);
            out_item_t w;
            if (step_out.size() >= RESULT_CAP)
                return;
            w.window_label = lbl;
            w.window_start = POS_OUT_W'(s);
            w.window_end   = POS_OUT_W'(e);
            w.broken       = brk;
            w.last_of_run  = 1'b0;
            step_out.push_back(w);
        endfunction

        // Close the run [s, e_excl); cut it into near-equal pieces, longer ones first.
        function void close_run(logic [LABEL_W-1:0] lbl, int unsigned s, int unsigned e_excl);
            int unsigned lim, dur, pieces, len, extra, pos, plen, i;
            if (e_excl <= s)
                return;
            lim = (max_len < MIN_WIN) ? MIN_WIN : max_len;
            dur = e_excl - s;
            if (dur <= lim)
            begin
                add_window(lbl, s, e_excl - 1, 1'b0);
                return;
            end
            pieces = (dur + lim - 1) / lim;
            len    = dur / pieces;
            extra  = dur % pieces;
            pos    = s;
            for (i = 0; i < pieces; i++)
            begin
                plen = len + ((i < extra) ? 1 : 0);
                add_window(lbl, pos, pos + plen - 1, 1'b1);
                pos += plen;
            end
        endfunction

        function void feed_label(logic [LABEL_W-1:0] lbl, int unsigned idx);
            if (idx < top_m)
                return;
            if (!run_open)
            begin
                run_open = 1'b1;
                run_lbl  = lbl;
                run_beg  = idx;
            end
            else if (lbl != run_lbl)
            begin
                close_run(run_lbl, run_beg, idx);
                run_lbl = lbl;
                run_beg = idx;
            end
        endfunction

        function void note_frame(in_item_t it);
            logic [LABEL_W-1:0] popped;
            int unsigned        depth;
            int unsigned        idx;
            out_item_t          w;
            step_out.delete();
            if (frame_cnt < FRAME_CAP)
            begin
                depth = (bot_m > MARGIN_CAP) ? MARGIN_CAP : bot_m;
                if (held_n < depth)
                begin
                    held[held_n] = it.frame_label;
                    held_n++;
                end
                else
                begin
                    // A lowered margin keeps the current depth: pop one, push one.
                    idx = frame_cnt - held_n;
                    if (held_n == 0)
                        popped = it.frame_label;
                    else
                    begin
                        popped = held[0];
                        for (int unsigned k = 1; k < held_n; k++)
                            held[k-1] = held[k];
                        held[held_n-1] = it.frame_label;
                    end
                    feed_label(popped, idx);
                end
                frame_cnt++;
            end
            if (it.segment_end)
            begin
                if (run_open)
                    close_run(run_lbl, run_beg, frame_cnt - held_n);
                clear_segment();
            end
            if (step_out.size() != 0)
            begin
                w = step_out.pop_back();
                w.last_of_run = 1'b1;
                step_out.push_back(w);
            end
            foreach (step_out[k])
                windows_due.push_back(step_out[k]);
        endfunction

        task report_mismatch(string what, int unsigned want, int unsigned got);
            mismatches++;
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        endtask

        task check_window(out_item_t got);
            out_item_t want;
            if (windows_due.size() == 0)
            begin
                report_mismatch("window with none due, label", 0, got.window_label);
                return;
            end
            want = windows_due.pop_front();
            if (got.window_label !== want.window_label)
                report_mismatch("window_label", want.window_label, got.window_label);
            if (got.window_start !== want.window_start)
                report_mismatch("window_start", want.window_start, got.window_start);
            if (got.window_end !== want.window_end)
                report_mismatch("window_end", want.window_end, got.window_end);
            if (got.broken !== want.broken)
                report_mismatch("broken", want.broken, got.broken);
            if (got.last_of_run !== want.last_of_run)
                report_mismatch("last_of_run", want.last_of_run, got.last_of_run);
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned stall_hold   = 0;
    int unsigned quiet_cycles = 0;

    window_tracker tracker = new();

    label_run_window_splitter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Receiver: a requested hold-off wins over random stalls.
    always @(posedge clk)
    begin
        if (stall_hold != 0)
        begin
            stall_hold = stall_hold - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_window(out_data);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_frame(logic [LABEL_W-1:0] lbl, bit last);
        in_item_t it;
        it.frame_label = lbl;
        it.segment_end = last;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_frame(it);
    endtask

    task automatic send_segment(int unsigned frames, int unsigned change_permille, bit close);
        logic [LABEL_W-1:0] lbl;
        lbl = LABEL_W'($urandom_range(0, 65535));
        for (int unsigned k = 0; k < frames; k++)
        begin
            if (k != 0 && $urandom_range(0, 999) < change_permille)
            begin
                if ($urandom_range(0, 1) != 0)
                    lbl = LABEL_W'($urandom_range(0, 65535));
                else
                    lbl = lbl ^ (16'd1 << $urandom_range(0, 15));
            end
            send_frame(lbl, close && (k == frames - 1));
        end
    endtask

    // Write the three registers back to back, optionally the unused index too.
    task automatic program_regs(logic [CFG_DATA_W-1:0] top, logic [CFG_DATA_W-1:0] bot,
                                logic [CFG_DATA_W-1:0] mwl, bit spare);
        logic [CFG_IDX_W-1:0]  idx[4];
        logic [CFG_DATA_W-1:0] val[4];
        int                    n;
        idx = '{REG_TOP_MARGIN, REG_BOTTOM_MARGIN, REG_MAX_WINDOW_LENGTH, REG_SPARE};
        val = '{top, bot, mwl, CFG_DATA_W'($urandom_range(0, 8191))};
        n   = spare ? 4 : 3;
        for (int k = 0; k < n; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            tracker.write_reg(idx[k], val[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, wait for every window due, then let the block go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.windows_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int unsigned snd, int unsigned rcv, int unsigned quota);
        int unsigned           sent;
        int unsigned           segs;
        int unsigned           len;
        logic [CFG_DATA_W-1:0] marg[2];
        logic [CFG_DATA_W-1:0] mwl;
        bit                    close;
        snd_idle_pct = snd;
        rcv_idle_pct = rcv;
        sent = 0;
        while (sent < quota)
        begin
            for (int k = 0; k < 2; k++)
            begin
                case ($urandom_range(0, 4))
                    0:       marg[k] = 0;
                    1:       marg[k] = 16;
                    2:       marg[k] = 31;
                    3:       marg[k] = CFG_DATA_W'($urandom_range(0, 8191));
                    default: marg[k] = CFG_DATA_W'($urandom_range(0, 16));
                endcase
            end
            case ($urandom_range(0, 6))
                0:       mwl = 0;
                1:       mwl = 127;
                2:       mwl = 128;
                3:       mwl = 4096;
                4:       mwl = 8191;
                5:       mwl = CFG_DATA_W'($urandom_range(0, 8191));
                default: mwl = CFG_DATA_W'($urandom_range(128, 300));
            endcase
            program_regs(marg[0], marg[1], mwl, 1'b0);
            segs = $urandom_range(1, 4);
            for (int unsigned s = 0; s < segs; s++)
            begin
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(130, 260)
                                                   : $urandom_range(1, 24);
                // leave the last segment open now and then across a register change
                close = (s + 1 < segs) || ($urandom_range(0, 1) != 0);
                send_segment(len, (len > 100) ? 5 : 300, close);
                sent += len;
            end
            settle();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: label extremes, two windows from one transaction, lone frame.
        snd_idle_pct = 20;
        rcv_idle_pct = 20;
        send_frame(16'h0000, 1'b0);
        send_frame(16'h0000, 1'b0);
        send_frame(16'hFFFF, 1'b0);
        send_frame(16'hFFFF, 1'b0);
        send_frame(16'hA5A5, 1'b1);
        send_frame(16'h5A5A, 1'b1);
        settle();

        // Margins cover the whole segment; zero window length acts as the minimum.
        program_regs(13'd2, 13'd3, 13'd0, 1'b1);
        send_frame(16'h0001, 1'b0);
        send_frame(16'h0001, 1'b0);
        send_frame(16'h0002, 1'b0);
        send_frame(16'h0002, 1'b1);
        // Hold a segment open across a margin change.
        send_frame(16'h0007, 1'b0);
        send_frame(16'h0007, 1'b0);
        send_frame(16'h0008, 1'b0);
        settle();
        program_regs(13'd1, 13'd1, 13'd128, 1'b0);
        send_frame(16'h0008, 1'b0);
        send_frame(16'h0008, 1'b0);
        send_frame(16'h0009, 1'b0);
        send_frame(16'h0009, 1'b0);
        send_frame(16'h0009, 1'b1);
        settle();

        run_phase(33, 78, 40);
        run_phase(78, 33, 40);

        // Receiver holds off while every frame closes a run, so the block backs up.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        program_regs(13'd0, 13'd0, 13'd128, 1'b0);
        stall_hold = 400;
        send_segment(40, 1000, 1'b1);
        settle();

        run_phase(0, 0, 40);

        if (tracker.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/lrws_pkg.sv
hdl/lrws_div.sv
hdl/lrws_dp.sv
hdl/lrws_ctrl.sv
hdl/label_run_window_splitter.sv
dv/label_run_window_splitter_tb.sv
